// File: design/nearest_neighbour_downscaler_macros.svh
// Assertion macros used by the downscaler RTL (nnd_sel).
// No dependencies; include by bare file name.
`ifndef NEAREST_NEIGHBOUR_DOWNSCALER_MACROS_SVH
`define NEAREST_NEIGHBOUR_DOWNSCALER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define NND_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nnd: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define NND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nnd: next-cycle check failed");

`endif

// File: design/nnd_pkg.sv
// Shared constants, types and helper functions for the downscaler.
// No dependencies.
package nnd_pkg;

    localparam int NND_MAX_DIM   = 4096;
    localparam int NND_PCT_BASE  = 100;
    localparam int NND_SCALE_W   = 7;
    localparam int NND_DIM_W     = 13;
    localparam int NND_PIX_W     = 8;
    localparam int NND_CFG_IDX_W = 2;
    localparam int NND_CFG_DAT_W = 13;

    localparam int NND_RST_SCALE  = 50;
    localparam int NND_RST_WIDTH  = 640;
    localparam int NND_RST_HEIGHT = 480;

    localparam logic [NND_CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
    localparam logic [NND_CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [NND_CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic hit;
        logic last;
    } t_sel;

    function automatic int nnd_clamp_dim(input int v, input int max_dim);
        int r;
        r = v;
        if (v < 1) begin
            r = 1;
        end else if (v > max_dim) begin
            r = max_dim;
        end
        return r;
    endfunction

endpackage

// File: design/nnd_if.sv
// Handshake interfaces for source pixels, output pixels and register writes.
// Depends on nnd_pkg.
interface nnd_pix_in_if;
    import nnd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [NND_PIX_W-1:0] in_red;
    logic [NND_PIX_W-1:0] in_green;
    logic [NND_PIX_W-1:0] in_blue;

    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface nnd_pix_out_if;
    import nnd_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [NND_PIX_W-1:0] out_red;
    logic [NND_PIX_W-1:0] out_green;
    logic [NND_PIX_W-1:0] out_blue;
    logic                 frame_last;

    modport source (output valid, out_red, out_green, out_blue, frame_last, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, frame_last, output ready);
endinterface

interface nnd_cfg_if;
    import nnd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [NND_CFG_IDX_W-1:0] index;
    logic [NND_CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: design/nnd_sel.sv
// Row/column selection: position counters and running target/source sums.
// Depends on nnd_pkg and nearest_neighbour_downscaler_macros.svh.
`include "nearest_neighbour_downscaler_macros.svh"

module nnd_sel #(
    parameter int MAX_DIM = nnd_pkg::NND_MAX_DIM,
    parameter int CW      = $clog2(MAX_DIM),
    parameter int SW      = $clog2(128 * MAX_DIM)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [nnd_pkg::NND_SCALE_W-1:0] i_scale,
    input  logic [CW-1:0]                i_w_last,
    input  logic [CW-1:0]                i_h_last,
    input  logic [SW-1:0]                i_wp,
    input  logic [SW-1:0]                i_hp,
    output nnd_pkg::t_sel                o_sel
);
    import nnd_pkg::*;

    localparam logic [SW:0] BASE1 = (SW+1)'(NND_PCT_BASE);
    localparam logic [SW:0] BASE2 = (SW+1)'(2 * NND_PCT_BASE);
    localparam logic [SW-1:0] BASE = SW'(NND_PCT_BASE);

    logic [CW-1:0] r_scol, n_scol;
    logic [CW-1:0] r_srow, n_srow;
    logic [SW-1:0] r_tsum_c, n_tsum_c;
    logic [SW-1:0] r_tsum_r, n_tsum_r;
    logic [SW-1:0] r_ssum_c, n_ssum_c;
    logic [SW-1:0] r_ssum_r, n_ssum_r;

    logic          p_ok;
    logic [SW:0]   p_ext;
    logic          col_sel, row_sel;
    logic          col_last, row_last;
    logic          row_end, frame_end;

    always_comb begin
        p_ok      = (i_scale != '0) && ({1'b0, i_scale} < 8'(NND_PCT_BASE));
        p_ext     = (SW+1)'(i_scale);
        col_sel   = p_ok && (({1'b0, r_tsum_c} + BASE1) <= {1'b0, i_wp})
                    && ({1'b0, r_tsum_c} < ({1'b0, r_ssum_c} + p_ext));
        row_sel   = p_ok && (({1'b0, r_tsum_r} + BASE1) <= {1'b0, i_hp})
                    && ({1'b0, r_tsum_r} < ({1'b0, r_ssum_r} + p_ext));
        col_last  = ({1'b0, r_tsum_c} + BASE2) > {1'b0, i_wp};
        row_last  = ({1'b0, r_tsum_r} + BASE2) > {1'b0, i_hp};
        row_end   = r_scol >= i_w_last;
        frame_end = r_srow >= i_h_last;

        o_sel.hit  = col_sel && row_sel;
        o_sel.last = col_last && row_last;

        n_scol   = r_scol;
        n_srow   = r_srow;
        n_tsum_c = r_tsum_c;
        n_tsum_r = r_tsum_r;
        n_ssum_c = r_ssum_c;
        n_ssum_r = r_ssum_r;
        if (i_accept) begin
            if (row_end) begin
                n_scol   = '0;
                n_tsum_c = '0;
                n_ssum_c = '0;
                if (frame_end) begin
                    n_srow   = '0;
                    n_tsum_r = '0;
                    n_ssum_r = '0;
                end else begin
                    if (row_sel) begin
                        n_tsum_r = r_tsum_r + BASE;
                    end
                    n_srow   = r_srow + 1'b1;
                    n_ssum_r = r_ssum_r + SW'(i_scale);
                end
            end else begin
                if (col_sel) begin
                    n_tsum_c = r_tsum_c + BASE;
                end
                n_scol   = r_scol + 1'b1;
                n_ssum_c = r_ssum_c + SW'(i_scale);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scol   <= '0;
            r_srow   <= '0;
            r_tsum_c <= '0;
            r_tsum_r <= '0;
            r_ssum_c <= '0;
            r_ssum_r <= '0;
        end else begin
            r_scol   <= n_scol;
            r_srow   <= n_srow;
            r_tsum_c <= n_tsum_c;
            r_tsum_r <= n_tsum_r;
            r_ssum_c <= n_ssum_c;
            r_ssum_r <= n_ssum_r;
        end
    end

    `NND_ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, i_rst_n && i_accept && row_end && frame_end, r_scol == '0 && r_srow == '0 && r_tsum_r == '0 && r_ssum_r == '0)
    `NND_ASSERT_NEXT(a_col_step, i_clk, i_rst_n, i_rst_n && i_accept && !row_end, r_scol == $past(r_scol) + 1'b1)
    `NND_ASSERT_NEXT(a_col_target, i_clk, i_rst_n, i_rst_n && i_accept && !row_end && col_sel, r_tsum_c == $past(r_tsum_c) + BASE)

endmodule

// File: design/nearest_neighbour_downscaler.sv
// Nearest-neighbor RGB downscaler: top level, register file and output register.
// Latency: a selected pixel appears on o_pix the cycle after its input transfer.
// Throughput: one source pixel per clock; o_pix stalls back-pressure i_pix only
// while the output register is full. Reset clears position state and loads
// scale 50, width 640, height 480. Depends on nnd_pkg, nnd_if and nnd_sel.
module nearest_neighbour_downscaler #(
    parameter int MAX_DIM = nnd_pkg::NND_MAX_DIM
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nnd_pix_in_if.sink        i_pix,
    nnd_pix_out_if.source     o_pix,
    nnd_cfg_if.sink           i_cfg
);
    import nnd_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int SW = $clog2(128 * MAX_DIM);

    localparam int RST_WC = nnd_clamp_dim(NND_RST_WIDTH, MAX_DIM);
    localparam int RST_HC = nnd_clamp_dim(NND_RST_HEIGHT, MAX_DIM);

    logic [NND_SCALE_W-1:0] r_scale;
    logic [DW-1:0]          r_wc, r_hc;
    logic [CW-1:0]          r_w_last, r_h_last;
    logic [SW-1:0]          r_wp, r_hp;

    logic [DW-1:0]          n_dim;
    logic [NND_SCALE_W-1:0] n_scale;

    logic                   accept;
    t_sel                   sel;

    logic                   r_out_valid;
    logic [NND_PIX_W-1:0]   r_red, r_green, r_blue;
    logic                   r_last;

    assign i_cfg.ready = 1'b1;
    assign n_dim       = DW'(nnd_clamp_dim(int'(i_cfg.data), MAX_DIM));
    assign n_scale     = i_cfg.data[NND_SCALE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= NND_SCALE_W'(NND_RST_SCALE);
            r_wc     <= DW'(RST_WC);
            r_hc     <= DW'(RST_HC);
            r_w_last <= CW'(RST_WC - 1);
            r_h_last <= CW'(RST_HC - 1);
            r_wp     <= SW'(RST_WC * NND_RST_SCALE);
            r_hp     <= SW'(RST_HC * NND_RST_SCALE);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_SCALE: begin
                    r_scale <= n_scale;
                    r_wp    <= SW'(r_wc) * SW'(n_scale);
                    r_hp    <= SW'(r_hc) * SW'(n_scale);
                end
                REG_WIDTH: begin
                    r_wc     <= n_dim;
                    r_w_last <= CW'(n_dim - 1'b1);
                    r_wp     <= SW'(n_dim) * SW'(r_scale);
                end
                REG_HEIGHT: begin
                    r_hc     <= n_dim;
                    r_h_last <= CW'(n_dim - 1'b1);
                    r_hp     <= SW'(n_dim) * SW'(r_scale);
                end
                default: begin
                end
            endcase
        end
    end

    assign i_pix.ready = !r_out_valid || o_pix.ready;
    assign accept      = i_pix.valid && i_pix.ready;

    nnd_sel #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW),
        .SW      (SW)
    ) u_sel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_scale  (r_scale),
        .i_w_last (r_w_last),
        .i_h_last (r_h_last),
        .i_wp     (r_wp),
        .i_hp     (r_hp),
        .o_sel    (sel)
    );

    // hold the result until the downstream transfer; reload on a selected pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && sel.hit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && sel.hit) begin
            r_red   <= i_pix.in_red;
            r_green <= i_pix.in_green;
            r_blue  <= i_pix.in_blue;
            r_last  <= sel.last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.out_red    = r_red;
    assign o_pix.out_green  = r_green;
    assign o_pix.out_blue   = r_blue;
    assign o_pix.frame_last = r_last;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the nearest-neighbor downscaler: streams pixels
// through the block and checks every output pixel and frame_last flag.
// Depends on nnd_pkg, the nnd_if interfaces and nearest_neighbour_downscaler.
module tb_top;
    import nnd_pkg::*;

    localparam logic [NND_CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1050;

    typedef struct packed {
        logic [NND_PIX_W-1:0] red;
        logic [NND_PIX_W-1:0] green;
        logic [NND_PIX_W-1:0] blue;
    } src_pixel_t;

    typedef struct packed {
        logic [NND_PIX_W-1:0] red;
        logic [NND_PIX_W-1:0] green;
        logic [NND_PIX_W-1:0] blue;
        logic                 last;
    } scaled_pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nnd_pix_in_if  pix_in ();
    nnd_pix_out_if pix_out ();
    nnd_cfg_if     cfg ();

    nearest_neighbour_downscaler u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg)
    );

    src_pixel_t    source_q[$];
    scaled_pixel_t scaled_q[$];
    int            error_count    = 0;
    int            accepted_items = 0;
    logic          in_xfer        = 1'b0;

    // Shadow registers and scan position of the block
    logic [NND_SCALE_W-1:0] m_scale;
    logic [NND_DIM_W-1:0]   m_width;
    logic [NND_DIM_W-1:0]   m_height;
    logic [11:0]            m_src_col, m_src_row, m_out_col, m_out_row;
    logic [18:0]            m_col_tgt, m_row_tgt, m_col_src, m_row_src;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic int idle_pct(input bit sink_side);
        if (accepted_items < 360) begin
            return sink_side ? 80 : 17;
        end else if (accepted_items < 720) begin
            return sink_side ? 17 : 80;
        end
        return 0;
    endfunction

    // Advance the scan position by one source pixel, queue the output pixel if selected
    task automatic downscale_step(input src_pixel_t px);
        int unsigned   p, w, h, out_w, out_h;
        bit            p_ok, col_sel, row_sel, frame_end;
        scaled_pixel_t sp;
        p = m_scale;
        w = (m_width < 1) ? 1 : ((m_width > NND_MAX_DIM) ? NND_MAX_DIM : m_width);
        h = (m_height < 1) ? 1 : ((m_height > NND_MAX_DIM) ? NND_MAX_DIM : m_height);
        p_ok = (p >= 1) && (p < NND_PCT_BASE);
        out_w = p_ok ? (w * p) / NND_PCT_BASE : 0;
        out_h = p_ok ? (h * p) / NND_PCT_BASE : 0;
        col_sel = p_ok && (m_out_col < out_w) && (int'(m_col_tgt) < int'(m_col_src) + p);
        row_sel = p_ok && (m_out_row < out_h) && (int'(m_row_tgt) < int'(m_row_src) + p);
        if (col_sel && row_sel) begin
            sp.red   = px.red;
            sp.green = px.green;
            sp.blue  = px.blue;
            sp.last  = (m_out_row == out_h - 1) && (m_out_col == out_w - 1);
            scaled_q.push_back(sp);
        end
        if (col_sel) begin
            m_out_col = m_out_col + 1'b1;
            m_col_tgt = m_col_tgt + 19'(NND_PCT_BASE);
        end
        if (m_src_col >= w - 1) begin
            frame_end = (m_src_row >= h - 1);
            m_src_col = '0;
            m_out_col = '0;
            m_col_tgt = '0;
            m_col_src = '0;
            if (frame_end) begin
                m_src_row = '0;
                m_out_row = '0;
                m_row_tgt = '0;
                m_row_src = '0;
            end else begin
                if (row_sel) begin
                    m_out_row = m_out_row + 1'b1;
                    m_row_tgt = m_row_tgt + 19'(NND_PCT_BASE);
                end
                m_src_row = m_src_row + 1'b1;
                m_row_src = m_row_src + 19'(p);
            end
        end else begin
            m_src_col = m_src_col + 1'b1;
            m_col_src = m_col_src + 19'(p);
        end
    endtask

    always @(posedge clk) begin : monitor
        scaled_pixel_t want;
        if (!rst_n) begin
            in_xfer   <= 1'b0;
            m_scale   = NND_SCALE_W'(NND_RST_SCALE);
            m_width   = NND_DIM_W'(NND_RST_WIDTH);
            m_height  = NND_DIM_W'(NND_RST_HEIGHT);
            m_src_col = '0;
            m_src_row = '0;
            m_out_col = '0;
            m_out_row = '0;
            m_col_tgt = '0;
            m_row_tgt = '0;
            m_col_src = '0;
            m_row_src = '0;
        end else begin
            in_xfer <= pix_in.valid && pix_in.ready;
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_SCALE: begin
                        m_scale = cfg.data[NND_SCALE_W-1:0];
                    end
                    REG_WIDTH: begin
                        m_width = cfg.data;
                    end
                    REG_HEIGHT: begin
                        m_height = cfg.data;
                    end
                    default: begin
                    end
                endcase
            end
            if (pix_out.valid && pix_out.ready) begin
                if (scaled_q.size() == 0) begin
                    report_mismatch("output pixel with nothing expected");
                end else begin
                    want = scaled_q.pop_front();
                    check_field("out_red", pix_out.out_red, want.red);
                    check_field("out_green", pix_out.out_green, want.green);
                    check_field("out_blue", pix_out.out_blue, want.blue);
                    check_field("frame_last", pix_out.frame_last, want.last);
                end
            end
            if (pix_in.valid && pix_in.ready) begin
                downscale_step({pix_in.in_red, pix_in.in_green, pix_in.in_blue});
                accepted_items++;
            end
        end
    end

    always @(negedge clk) begin : pixel_driver
        src_pixel_t px;
        if (!rst_n) begin
            pix_in.valid <= 1'b0;
        end else if (!pix_in.valid || in_xfer) begin
            if (source_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                px = source_q.pop_front();
                pix_in.valid <= 1'b1;
            end else begin
                px = src_pixel_t'($urandom);
                pix_in.valid <= 1'b0;
            end
            pix_in.in_red   <= px.red;
            pix_in.in_green <= px.green;
            pix_in.in_blue  <= px.blue;
        end
    end

    always @(negedge clk) begin
        pix_out.ready <= rst_n && ($urandom_range(99) >= idle_pct(1'b1));
    end

    task automatic write_reg(input logic [NND_CFG_IDX_W-1:0] idx,
                             input logic [NND_CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic configure(input int scale, input int width, input int height);
        write_reg(REG_SCALE, NND_CFG_DAT_W'(scale));
        write_reg(REG_WIDTH, NND_CFG_DAT_W'(width));
        write_reg(REG_HEIGHT, NND_CFG_DAT_W'(height));
    endtask

    task automatic queue_random(input int n);
        repeat (n) source_q.push_back(src_pixel_t'($urandom));
    endtask

    // Hold until every pixel is taken and every output pixel is back
    task automatic settle();
        while (source_q.size() != 0 || pix_in.valid || scaled_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    initial begin : stimulus
        int scale_val, width_val, height_val, wc, hc, n, r;
        int random_items;
        pix_in.valid    = 1'b0;
        pix_in.in_red   = '0;
        pix_in.in_green = '0;
        pix_in.in_blue  = '0;
        pix_out.ready   = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        random_items    = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 640 x 480 at half scale
        source_q.push_back({8'h00, 8'h00, 8'h00});
        source_q.push_back({8'hFF, 8'hFF, 8'hFF});
        source_q.push_back({8'hFF, 8'h00, 8'h5A});
        settle();

        // Shrink the frame mid-row, then a write to the unused index
        configure(67, 3, 2);
        write_reg(REG_UNUSED, '1);
        queue_random(5);
        settle();

        configure(99, 2, 2);
        source_q.push_back({8'h00, 8'hFF, 8'hA5});
        queue_random(3);
        settle();

        // Smallest factor on an oversized, clamped width
        configure(1, 8191, 200);
        queue_random(3);
        settle();

        // Factors outside 1..99 give no output
        write_reg(REG_SCALE, NND_CFG_DAT_W'(0));
        queue_random(2);
        settle();
        write_reg(REG_SCALE, NND_CFG_DAT_W'(NND_PCT_BASE));
        queue_random(2);
        settle();
        write_reg(REG_SCALE, '1);
        queue_random(2);
        settle();

        // Zero dimensions clamp to one
        configure(50, 0, 0);
        queue_random(2);
        settle();

        configure(99, NND_MAX_DIM, NND_MAX_DIM);
        queue_random(3);
        settle();

        while (random_items < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 8) begin
                scale_val = ($urandom_range(1) == 0) ? 0 : $urandom_range(127, NND_PCT_BASE);
            end else if (r < 12) begin
                scale_val = $urandom_range(8191);
            end else if (r < 18) begin
                scale_val = ($urandom_range(1) == 0) ? 1 : 99;
            end else begin
                scale_val = $urandom_range(99, 1);
            end
            r = $urandom_range(99);
            if (r < 5) begin
                width_val = $urandom_range(8191);
            end else if (r < 8) begin
                width_val = 0;
            end else begin
                width_val = $urandom_range(12, 1);
            end
            r = $urandom_range(99);
            if (r < 5) begin
                height_val = $urandom_range(8191);
            end else if (r < 8) begin
                height_val = 0;
            end else begin
                height_val = $urandom_range(6, 1);
            end
            configure(scale_val, width_val, height_val);
            if ($urandom_range(9) == 0) begin
                write_reg(REG_UNUSED, NND_CFG_DAT_W'($urandom));
            end

            wc = (width_val < 1) ? 1 : ((width_val > NND_MAX_DIM) ? NND_MAX_DIM : width_val);
            hc = (height_val < 1) ? 1 : ((height_val > NND_MAX_DIM) ? NND_MAX_DIM : height_val);
            n = wc * hc * $urandom_range(3, 1);
            if (n > 60) begin
                n = $urandom_range(60, 20);
            end
            // Break off a frame now and then
            if ($urandom_range(3) == 0) begin
                n = n + $urandom_range(3, 1);
            end
            queue_random(n);
            random_items += n;
            settle();
        end

        repeat (8) @(posedge clk);
        if (scaled_q.size() != 0) begin
            report_mismatch($sformatf("%0d output pixels never arrived", scaled_q.size()));
        end
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
